### sv/msd_pkg.sv
// shared constants, types and controller states for the monotonic stack depth block
package msd_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 7;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [CNT_W-1:0]   DEPTH_CNT    = CNT_W'(DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_MASKED = DEPTH_W'(DEPTH % (1 << DEPTH_W));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMP,
        ST_PUSH
    } msd_state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic pop;
        logic emit;
    } msd_cmd_t;

    typedef struct packed {
        logic empty;
        logic le;
        logic out_free;
    } msd_sts_t;

endpackage

### sv/msd_if.sv
// valid/ready channel interfaces for the input and result items
interface msd_in_if import msd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      first;

    modport source (output valid, output value, output first, input ready);
    modport sink (input valid, input value, input first, output ready);
endinterface

interface msd_out_if import msd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth;
    logic               overflow;

    modport source (output valid, output depth, output overflow, input ready);
    modport sink (input valid, input depth, input overflow, output ready);
endinterface

### sv/monotonic_stack_depth.sv
// monotonic_stack_depth top level: previous-greater depth tracker over a bounded stack
//
// in_ch carries one value per item with a first flag that empties the stack
// before the item. out_ch returns exactly one result per item: the stack depth
// after the push, or DEPTH with overflow set when the stack stayed full.
// Both channels move an item when valid and ready are high at a clock edge.
// One item is in work at a time. After acceptance the controller reads the top
// entry and compares it with the item; an entry that is not above the item is
// popped, and the read and compare repeat on the stack memory until the stack
// is empty or the top entry is above the item. The item is then pushed, unless
// the stack is full, and its result emitted once the output register is free.
// The controller returns to idle after each result before it takes the next
// item. Each stored value is popped at most once.
// The result sits in an output register, so the next item is accepted while
// the previous result still waits; a stalled receiver only holds the block
// when a second result is ready to leave.
// Reset empties the stack and clears the output valid flag; stack memory is
// not cleared, as only entries below the count are ever read.
module monotonic_stack_depth import msd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    msd_in_if.sink           in_ch,
    msd_out_if.source        out_ch
);

    msd_cmd_t cmd;
    msd_sts_t sts;

    msd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_value     (in_ch.value),
        .in_first     (in_ch.first),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_depth    (out_ch.depth),
        .out_overflow (out_ch.overflow)
    );

    a_ovf_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.overflow |-> out_ch.depth == DEPTH_MASKED)
        else $error("overflow result with depth other than DEPTH");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("second item accepted while one is in work");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.empty)
        else $error("pop from an empty stack");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.depth))
        else $error("result overwritten while stalled");

endmodule

### sv/msd_ctrl.sv
// controller state machine sequencing load, compare/pop and push of one item
module msd_ctrl import msd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  msd_sts_t sts,
    output msd_cmd_t cmd
);

    msd_state_t state_reg;
    msd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.empty)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                // top entry not above the item: drop it and look at the next one
                if (sts.le)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/msd_dp.sv
// datapath: stack memory, count, compare and the result register
module msd_dp import msd_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  msd_cmd_t                  cmd,
    output msd_sts_t                  sts,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                      in_first,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DEPTH_W-1:0]        out_depth,
    output logic                      out_overflow
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic                      overflow_reg;

    logic                      full;
    logic [CNT_W-1:0]          count_dec;
    logic [CNT_W-1:0]          count_inc;
    logic [CNT_W-1:0]          depth_cnt;
    logic [CNT_W+DEPTH_W-1:0]  depth_ext;

    assign full      = (count_reg == DEPTH_CNT);
    assign count_dec = count_reg - CNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);
    assign depth_cnt = full ? count_reg : count_inc;
    // depth field keeps only its low bits
    assign depth_ext = {{DEPTH_W{1'b0}}, depth_cnt};

    assign sts.empty    = (count_reg == '0);
    assign sts.le       = (rdata_reg <= value_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = in_first ? '0 : count_reg;
        end
        else if (cmd.pop)
        begin
            count_next = count_dec;
        end
        else if (cmd.emit && !full)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= in_value;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[count_dec[ADDR_W-1:0]];
        end
        if (cmd.emit && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.emit)
        begin
            depth_reg    <= depth_ext[DEPTH_W-1:0];
            overflow_reg <= full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_depth    = depth_reg;
    assign out_overflow = overflow_reg;

endmodule
